/* rtl/core/dtc_pkg.sv */
// Shared types and constants of the decision tree classifier.
`default_nettype none
package dtc_pkg;

   localparam int FEATURE_SLOTS = 7;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] ACT_NODE     = 2'd0;
   localparam logic [1:0] ACT_FEATURE  = 2'd1;
   localparam logic [1:0] ACT_CLASSIFY = 2'd2;

   typedef enum logic [1:0] {
      OP_NODE,
      OP_FEATURE,
      OP_CLASSIFY,
      OP_BAD_TREE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [1:0]         tree;
      logic [7:0]         node_index;
      logic signed [8:0]  left_child;
      logic signed [8:0]  right_child;
      logic [2:0]         feature_select;
      logic [63:0]        compare_word;
      logic signed [31:0] leaf_value;
   } cmd_type;

   typedef struct packed {
      logic signed [8:0]  left_child;
      logic signed [8:0]  right_child;
      logic [2:0]         feature_select;
      logic [63:0]        threshold;
      logic signed [31:0] value;
   } node_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_WALK
   } back_state_type;

endpackage
`default_nettype wire

/* rtl/core/decision_tree_classifier.sv */
// Decision tree classifier top level: request decode, command queue, tree walker.
// With an empty queue, the back end pops a classify, reads node 0, walks the tree
// and loads the response register when the walk ends and the response slot is free;
// a classify on a bad tree loads it from the idle state. Writes execute one per cycle
// while the back end is idle; a classify holds the back end until its walk ends.
// Reset clears queue, walker state, response valid and feature values, not node tables.
`default_nettype none
module decision_tree_classifier #(
   parameter int NODES_PER_TREE = 256,
   parameter int WALK_DEPTH     = 16,
   parameter int TREE_COUNT     = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tree_select[1:0], node_index[9:2], left_child[18:10], right_child[27:19],
   // feature_select[30:28], compare_word[94:31], leaf_value[126:95], zero[127]
   input  wire logic [127:0] req_tdata,
   // action[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // class_value[31:0]
   output logic [31:0]       rsp_tdata,
   // bad_tree[0]
   output logic [0:0]        rsp_tuser
);
   import dtc_pkg::*;

   queue_status_type   q_status;
   queue_ctl_type      q_ctl;
   cmd_type            push_cmd;
   cmd_type            head_cmd;
   logic               q_push;
   logic               q_pop;
   logic signed [31:0] class_value;
   logic               bad_tree;

   assign q_ctl.push = q_push;
   assign q_ctl.pop  = q_pop;

   dtc_front #(
      .NODES_PER_TREE(NODES_PER_TREE),
      .TREE_COUNT    (TREE_COUNT)
   ) u_front (
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .action        (req_tuser),
      .tree_select   (req_tdata[1:0]),
      .node_index    (req_tdata[9:2]),
      .left_child    (req_tdata[18:10]),
      .right_child   (req_tdata[27:19]),
      .feature_select(req_tdata[30:28]),
      .compare_word  (req_tdata[94:31]),
      .leaf_value    (req_tdata[126:95]),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   dtc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (q_ctl),
      .wr_cmd(push_cmd),
      .rd_cmd(head_cmd),
      .status(q_status)
   );

   dtc_back #(
      .NODES_PER_TREE(NODES_PER_TREE),
      .WALK_DEPTH    (WALK_DEPTH),
      .TREE_COUNT    (TREE_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_cmd      (head_cmd),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .class_value(class_value),
      .bad_tree   (bad_tree)
   );

   assign rsp_tdata    = class_value;
   assign rsp_tuser[0] = bad_tree;

endmodule
`default_nettype wire

/* rtl/core/dtc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module dtc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/dtc_front.sv */
// Front end: accepts requests, checks them and turns them into queue commands.
`default_nettype none
module dtc_front #(
   parameter int NODES_PER_TREE = 256,
   parameter int TREE_COUNT     = 3
) (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                action,
   input  wire logic [1:0]                tree_select,
   input  wire logic [7:0]                node_index,
   input  wire logic signed [8:0]         left_child,
   input  wire logic signed [8:0]         right_child,
   input  wire logic [2:0]                feature_select,
   input  wire logic [63:0]               compare_word,
   input  wire logic signed [31:0]        leaf_value,
   input  wire dtc_pkg::queue_status_type q_status,
   output logic                           q_push,
   output dtc_pkg::cmd_type               q_cmd
);
   import dtc_pkg::*;

   logic tree_ok;
   logic node_ok;
   logic keep;

   assign tree_ok   = (tree_select != 2'd0) && (int'(tree_select) <= TREE_COUNT);
   assign node_ok   = int'(node_index) < NODES_PER_TREE;
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready && keep;

   always_comb begin
      keep                = 1'b0;
      q_cmd.op            = OP_CLASSIFY;
      q_cmd.tree          = tree_select;
      q_cmd.node_index    = node_index;
      q_cmd.left_child    = left_child;
      q_cmd.right_child   = right_child;
      q_cmd.feature_select = feature_select;
      q_cmd.compare_word  = compare_word;
      q_cmd.leaf_value    = leaf_value;
      unique case (action)
         ACT_NODE: begin
            q_cmd.op = OP_NODE;
            keep     = tree_ok && node_ok;
         end
         ACT_FEATURE: begin
            q_cmd.op = OP_FEATURE;
            keep     = int'(feature_select) < FEATURE_SLOTS;
         end
         ACT_CLASSIFY: begin
            q_cmd.op = tree_ok ? OP_CLASSIFY : OP_BAD_TREE;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/dtc_queue.sv */
// Short command queue between front and back end.
`default_nettype none
module dtc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dtc_pkg::queue_ctl_type    ctl,
   input  wire dtc_pkg::cmd_type          wr_cmd,
   output dtc_pkg::cmd_type               rd_cmd,
   output dtc_pkg::queue_status_type      status
);
   import dtc_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign status.full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign rd_cmd       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = ctl.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = ctl.pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!ctl.push && ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/dtc_back.sv */
// Back end: executes node and feature writes and walks trees for classify.
`default_nettype none
module dtc_back #(
   parameter int NODES_PER_TREE = 256,
   parameter int WALK_DEPTH     = 16,
   parameter int TREE_COUNT     = 3
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire dtc_pkg::queue_status_type q_status,
   input  wire dtc_pkg::cmd_type          q_cmd,
   output logic                           q_pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic signed [31:0]             class_value,
   output logic                           bad_tree
);
   import dtc_pkg::*;

   localparam int TABLE_SIZE = TREE_COUNT * NODES_PER_TREE;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int STEP_W     = $clog2(WALK_DEPTH + 1);

   back_state_type     state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [63:0]        feat_ff, feat_in;
   logic [63:0]        store_ff [FEATURE_SLOTS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] value_ff, value_in;
   logic               bad_ff, bad_in;
   logic               rsp_load;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   node_type           wr_node;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   node_type           node;

   logic [ADDR_W-1:0]  cmd_base;
   logic               slot_free;
   logic [63:0]        cur_feat;
   logic signed [8:0]  next;
   logic               done;

   dtc_ram #(
      .WIDTH($bits(node_type)),
      .DEPTH(TABLE_SIZE)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_node),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(node)
   );

   assign cmd_base  = ADDR_W'((int'(q_cmd.tree) - 1) * NODES_PER_TREE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign wr_addr   = ADDR_W'(int'(cmd_base) + int'(q_cmd.node_index));

   assign wr_node.left_child     = q_cmd.left_child;
   assign wr_node.right_child    = q_cmd.right_child;
   assign wr_node.feature_select = q_cmd.feature_select;
   assign wr_node.threshold      = q_cmd.compare_word;
   assign wr_node.value          = q_cmd.leaf_value;

   // feature index seven keeps the last compared value
   assign cur_feat = (int'(node.feature_select) < FEATURE_SLOTS)
                     ? store_ff[node.feature_select] : feat_ff;
   assign next     = (cur_feat <= node.threshold) ? node.left_child : node.right_child;
   assign done     = node.left_child[8] || (step_ff == STEP_W'(WALK_DEPTH)) ||
                     next[8] || (int'(next[7:0]) >= NODES_PER_TREE);

   always_comb begin
      state_in = state_ff;
      base_in  = base_ff;
      step_in  = step_ff;
      feat_in  = feat_ff;
      value_in = value_ff;
      bad_in   = bad_ff;
      rsp_load = 1'b0;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      rd_en    = 1'b0;
      rd_addr  = cmd_base;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               unique case (q_cmd.op)
                  OP_NODE: begin
                     wr_en = 1'b1;
                     q_pop = 1'b1;
                  end
                  OP_FEATURE: begin
                     q_pop = 1'b1;
                  end
                  OP_BAD_TREE: begin
                     if (slot_free) begin
                        rsp_load = 1'b1;
                        value_in = -32'sd1;
                        bad_in   = 1'b1;
                        q_pop    = 1'b1;
                     end
                  end
                  OP_CLASSIFY: begin
                     rd_en    = 1'b1;
                     base_in  = cmd_base;
                     step_in  = '0;
                     feat_in  = '0;
                     q_pop    = 1'b1;
                     state_in = BACK_WALK;
                  end
                  default: begin
                     q_pop = 1'b0;
                  end
               endcase
            end
         end
         BACK_WALK: begin
            rd_addr = base_ff + ADDR_W'(next[7:0]);
            if (done) begin
               if (slot_free) begin
                  rsp_load = 1'b1;
                  value_in = node.value;
                  bad_in   = 1'b0;
                  state_in = BACK_IDLE;
               end
            end else begin
               rd_en   = 1'b1;
               step_in = step_ff + 1'b1;
               feat_in = cur_feat;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FEATURE_SLOTS; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == BACK_IDLE && !q_status.empty && q_cmd.op == OP_FEATURE) begin
            store_ff[q_cmd.feature_select] <= q_cmd.compare_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff  <= base_in;
      step_ff  <= step_in;
      feat_ff  <= feat_in;
      value_ff <= value_in;
      bad_ff   <= bad_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign class_value = value_ff;
   assign bad_tree    = bad_ff;

endmodule
`default_nettype wire

/* tb/decision_tree_classifier_test.sv */
// Self-checking stream testbench for the decision tree classifier: directed and random tree builds and walks.
`timescale 1ns / 1ps
module decision_tree_classifier_test;
   import dtc_pkg::*;

   localparam int NODES_PER_TREE = 256;
   localparam int WALK_DEPTH     = 16;
   localparam int TREE_COUNT     = 3;
   localparam int TABLE_SIZE     = TREE_COUNT * NODES_PER_TREE;
   localparam int CLOCK_PERIOD   = 10;
   localparam int ITEM_TARGET    = 1950;
   localparam int MAX_GAP        = 18;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AT        = 320;
   localparam int MAX_REPORTS    = 10;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [1:0] NO_TREE    = 2'd0;

   typedef struct packed {
      logic signed [31:0] class_value;
      logic               bad_tree;
   } class_result_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         tree;
      logic [7:0]         node_index;
      logic signed [8:0]  left_child;
      logic signed [8:0]  right_child;
      logic [2:0]         feature_select;
      logic [63:0]        compare_word;
      logic signed [31:0] leaf_value;
      int                 gap;
      bit                 wait_drain;
      bit                 has_result;
      class_result_type   result;
   } request_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [31:0]  rsp_tdata;
   logic [0:0]   rsp_tuser;

   decision_tree_classifier #(
      .NODES_PER_TREE(NODES_PER_TREE),
      .WALK_DEPTH    (WALK_DEPTH),
      .TREE_COUNT    (TREE_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // shadow of the node tables and feature values
   logic signed [8:0]  left_tbl    [TABLE_SIZE];
   logic signed [8:0]  right_tbl   [TABLE_SIZE];
   logic [2:0]         feature_tbl [TABLE_SIZE];
   logic [63:0]        thresh_tbl  [TABLE_SIZE];
   logic signed [31:0] value_tbl   [TABLE_SIZE];
   bit                 node_written[TABLE_SIZE];
   logic [63:0]        feature_vals[FEATURE_SLOTS];

   request_type      pending_requests[$];
   class_result_type expected_classes[$];

   int  error_count = 0;
   int  accepted_count = 0;
   int  checked_count = 0;
   int  useful_items = 0;
   int  classify_count = 0;
   int  bad_tree_count = 0;
   int  depth_bound_count = 0;
   int  node_write_count = 0;
   int  feature_write_count = 0;
   int  send_gap = 0;
   int  rsp_wait = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  req_taken = 0;

   // Walks one tree from node 0. missing is the first unwritten node read, or -1.
   function automatic logic signed [31:0] classify_walk(input logic [1:0] tree,
                                                        output int missing,
                                                        output bit bounded);
      int                base;
      int                node;
      int                slot;
      int                step;
      bit                stopped;
      logic [63:0]       feat;
      logic signed [8:0] next;
      base    = (int'(tree) - 1) * NODES_PER_TREE;
      node    = 0;
      feat    = '0;
      stopped = 0;
      missing = -1;
      bounded = 0;
      for (step = 0; step < WALK_DEPTH && !stopped; step++) begin
         slot = base + node;
         if (!node_written[slot]) begin
            missing = node;
            return '0;
         end
         if (left_tbl[slot] < 0) begin
            stopped = 1;
         end else begin
            if (feature_tbl[slot] < FEATURE_SLOTS)
               feat = feature_vals[feature_tbl[slot]];
            next = (feat <= thresh_tbl[slot]) ? left_tbl[slot] : right_tbl[slot];
            if (next < 0 || next >= NODES_PER_TREE)
               stopped = 1;
            else
               node = int'(next);
         end
      end
      bounded = !stopped;
      if (!node_written[base + node]) begin
         missing = node;
         return '0;
      end
      return value_tbl[base + node];
   endfunction

   function automatic void apply_request(inout request_type rq);
      int slot;
      int missing;
      bit bounded;
      rq.has_result = 0;
      rq.result     = '0;
      case (rq.action)
         ACT_NODE: begin
            if (rq.tree >= 1 && rq.tree <= TREE_COUNT &&
                rq.node_index < NODES_PER_TREE) begin
               slot = (int'(rq.tree) - 1) * NODES_PER_TREE + int'(rq.node_index);
               left_tbl[slot]     = rq.left_child;
               right_tbl[slot]    = rq.right_child;
               feature_tbl[slot]  = rq.feature_select;
               thresh_tbl[slot]   = rq.compare_word;
               value_tbl[slot]    = rq.leaf_value;
               node_written[slot] = 1;
               node_write_count++;
            end
         end
         ACT_FEATURE: begin
            if (rq.feature_select < FEATURE_SLOTS) begin
               feature_vals[rq.feature_select] = rq.compare_word;
               feature_write_count++;
            end
         end
         ACT_CLASSIFY: begin
            rq.has_result = 1;
            classify_count++;
            if (rq.tree < 1 || rq.tree > TREE_COUNT) begin
               rq.result.class_value = -32'sd1;
               rq.result.bad_tree    = 1'b1;
               bad_tree_count++;
            end else begin
               rq.result.class_value = classify_walk(rq.tree, missing, bounded);
               rq.result.bad_tree    = 1'b0;
               if (bounded)
                  depth_bound_count++;
            end
         end
         default: ;
      endcase
   endfunction

   task automatic push_request(input logic [1:0] action, input logic [1:0] tree,
                               input logic [7:0] node, input logic signed [8:0] left,
                               input logic signed [8:0] right, input logic [2:0] fsel,
                               input logic [63:0] word, input logic signed [31:0] leaf);
      request_type rq;
      rq.action         = action;
      rq.tree           = tree;
      rq.node_index     = node;
      rq.left_child     = left;
      rq.right_child    = right;
      rq.feature_select = fsel;
      rq.compare_word   = word;
      rq.leaf_value     = leaf;
      rq.gap            = ((pending_requests.size() / 150) % 3 == 2) ? 0
                          : $urandom_range(0, MAX_GAP);
      rq.wait_drain     = (pending_requests.size() % 700 == 699);
      apply_request(rq);
      pending_requests = {pending_requests, rq};
      if (action != ACT_UNUSED)
         useful_items++;
   endtask

   function automatic logic [63:0] random_word();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // mostly small indexes so walks run deep and loop back
   function automatic logic signed [8:0] random_child(input int neg_pct);
      int pick;
      int v;
      pick = $urandom_range(0, 99);
      if (pick < neg_pct)
         v = -int'($urandom_range(1, 256));
      else if (pick < 88)
         v = $urandom_range(0, 12);
      else
         v = $urandom_range(0, 255);
      return v[8:0];
   endfunction

   task automatic push_random_node(input logic [1:0] tree, input logic [7:0] node);
      push_request(ACT_NODE, tree, node, random_child(25), random_child(8),
                   3'($urandom_range(0, 7)), random_word(), $urandom);
   endtask

   task automatic push_random_classify(input logic [1:0] tree);
      int missing;
      bit bounded;
      if (tree != NO_TREE) begin
         void'(classify_walk(tree, missing, bounded));
         while (missing >= 0) begin
            push_random_node(tree, missing[7:0]);
            void'(classify_walk(tree, missing, bounded));
         end
      end
      push_request(ACT_CLASSIFY, tree, 8'($urandom), 9'($urandom), 9'($urandom),
                   3'($urandom), {$urandom, $urandom}, $urandom);
   endtask

   task automatic build_stimulus();
      int          pick;
      int          slot;
      logic [1:0]  tree;
      logic [2:0]  fsel;
      logic [63:0] word;
      // directed part
      push_request(ACT_CLASSIFY, NO_TREE, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      push_request(ACT_NODE, 2'd1, 8'd0, -9'sd1, 9'sd0, 3'd0, '1, 32'sh7FFF_FFFF);
      push_request(ACT_CLASSIFY, 2'd1, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      push_request(ACT_NODE, 2'd2, 8'd0, 9'sd1, 9'sd2, 3'd0, '0, 32'sd5);
      push_request(ACT_NODE, 2'd2, 8'd1, -9'sd256, 9'sd255, 3'd7, '1, -32'sh8000_0000);
      push_request(ACT_NODE, 2'd2, 8'd2, -9'sd1, -9'sd256, 3'd0, '0, 32'sd1);
      push_request(ACT_CLASSIFY, 2'd2, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      push_request(ACT_FEATURE, 2'd0, 8'd0, 9'sd0, 9'sd0, 3'd0, '1, 32'sd0);
      push_request(ACT_CLASSIFY, 2'd2, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      push_request(ACT_FEATURE, 2'd0, 8'd0, 9'sd0, 9'sd0, 3'd7, 64'd5, 32'sd0);
      // self loop on a reused zero feature runs out the depth
      push_request(ACT_NODE, 2'd3, 8'd0, 9'sd0, 9'sd0, 3'd7, '1, 32'sd77);
      push_request(ACT_CLASSIFY, 2'd3, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      // negative right child ends the walk at the current node
      push_request(ACT_FEATURE, 2'd0, 8'd0, 9'sd0, 9'sd0, 3'd6, 64'd1, 32'sd0);
      push_request(ACT_NODE, 2'd3, 8'd0, 9'sd1, -9'sd1, 3'd6, '0, 32'sd88);
      push_request(ACT_CLASSIFY, 2'd3, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd0);
      push_request(ACT_NODE, 2'd1, 8'd255, 9'sd255, 9'sd255, 3'd7, '1, 32'sh7FFF_FFFF);
      push_request(ACT_NODE, NO_TREE, 8'd0, 9'sd0, 9'sd0, 3'd0, '0, 32'sd9);
      push_request(ACT_UNUSED, 2'd1, 8'hFF, -9'sd1, -9'sd1, 3'd7, '1, -32'sd1);
      push_request(ACT_CLASSIFY, 2'd1, 8'hFF, -9'sd1, -9'sd1, 3'd7, '1, -32'sd1);
      // random part
      while (useful_items < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         tree = 2'($urandom_range(1, TREE_COUNT));
         if (pick < 45) begin
            push_random_classify(($urandom_range(0, 19) == 0) ? NO_TREE : tree);
         end else if (pick < 72) begin
            if ($urandom_range(0, 19) == 0)
               tree = NO_TREE;
            push_random_node(tree, 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                                 : $urandom_range(0, 255)));
         end else if (pick < 95) begin
            fsel = 3'($urandom_range(0, 7));
            word = random_word();
            slot = (int'(tree) - 1) * NODES_PER_TREE + int'($urandom_range(0, 12));
            // land exactly on a threshold now and then
            if ($urandom_range(0, 9) == 0 && node_written[slot])
               word = thresh_tbl[slot];
            push_request(ACT_FEATURE, 2'($urandom), 8'($urandom), 9'($urandom),
                         9'($urandom), fsel, word, $urandom);
         end else begin
            push_request(ACT_UNUSED, 2'($urandom), 8'($urandom), 9'($urandom),
                         9'($urandom), 3'($urandom), {$urandom, $urandom}, $urandom);
         end
      end
   endtask

   // request side
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         if (pending_requests[0].has_result)
            expected_classes = {expected_classes, pending_requests[0].result};
         void'(pending_requests.pop_front());
         accepted_count++;
         send_gap  = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (req_taken || !req_tvalid)) begin
         req_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() != 0 &&
                      !(pending_requests[0].wait_drain && expected_classes.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_requests[0].action;
            req_tdata  <= {1'b0, pending_requests[0].leaf_value,
                           pending_requests[0].compare_word,
                           pending_requests[0].feature_select,
                           pending_requests[0].right_child,
                           pending_requests[0].left_child,
                           pending_requests[0].node_index,
                           pending_requests[0].tree};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side
   always @(posedge clock) begin
      class_result_type exp_class;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_classes.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("%0t: unexpected result value %0d bad_tree %0b",
                        $realtime, $signed(rsp_tdata), rsp_tuser[0]);
            error_count++;
         end else begin
            exp_class = expected_classes.pop_front();
            if (rsp_tdata !== exp_class.class_value || rsp_tuser[0] !== exp_class.bad_tree) begin
               if (error_count < MAX_REPORTS)
                  $display({"%0t: result %0d expected value %0d bad_tree %0b, ",
                            "got %0d bad_tree %0b"},
                           $realtime, checked_count, exp_class.class_value, exp_class.bad_tree,
                           $signed(rsp_tdata), rsp_tuser[0]);
               error_count++;
            end
         end
         checked_count++;
         rsp_wait = ((checked_count / 50) % 3 != 0) ? $urandom_range(0, MAX_GAP) : 0;
      end
   end

   // one long back-pressure stretch while requests keep coming
   always @(posedge clock) begin
      if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_left = LONG_HOLD;
         hold_done = 1;
      end else if (hold_left > 0) begin
         hold_left--;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      foreach (feature_vals[i])
         feature_vals[i] = '0;
      build_stimulus();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (pending_requests.size() != 0 || expected_classes.size() != 0)
         @(posedge clock);
      repeat (WALK_DEPTH + 8) @(posedge clock);
      $display("Covered %0d requests: %0d classifies, %0d on a bad tree, %0d hit the depth bound.",
               accepted_count, classify_count, bad_tree_count, depth_bound_count);
      $display("Applied %0d node writes and %0d feature writes; checked %0d results.",
               node_write_count, feature_write_count, checked_count);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #(CLOCK_PERIOD * 500_000);
      $display("Timeout after %0d results", checked_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
